// ----- rtl/core/ksc_pkg.sv -----
// Shared types and code point constants for the kana script converter.
package ksc_pkg;

  typedef logic [20:0] code_t;
  typedef logic [2:0]  vowel_t;
  typedef logic [1:0]  mode_t;

  typedef struct packed {
    code_t code_point;
    logic  start_of_text;
  } ksc_in_t;

  typedef struct packed {
    code_t converted_point;
    logic  was_changed;
  } ksc_out_t;

  localparam mode_t MODE_PASS = 2'd0;
  localparam mode_t MODE_K2H  = 2'd1;
  localparam mode_t MODE_H2K  = 2'd2;

  localparam vowel_t VOWEL_NONE = 3'd0;
  localparam vowel_t VOWEL_A    = 3'd1;
  localparam vowel_t VOWEL_I    = 3'd2;
  localparam vowel_t VOWEL_U    = 3'd3;
  localparam vowel_t VOWEL_E    = 3'd4;
  localparam vowel_t VOWEL_O    = 3'd5;

  localparam code_t HIRA_FIRST    = 21'h03041;
  localparam code_t HIRA_LAST     = 21'h03096;
  localparam code_t KATA_FIRST    = 21'h030A1;
  localparam code_t KATA_LAST     = 21'h030F4;
  localparam code_t KATA_SMALL_KA = 21'h030F5;
  localparam code_t KATA_SMALL_KE = 21'h030F6;
  localparam code_t PROLONG_MARK  = 21'h030FC;
  localparam code_t KANA_SHIFT    = 21'h00060;

  localparam code_t HIRA_A = 21'h03042;
  localparam code_t HIRA_I = 21'h03044;
  localparam code_t HIRA_U = 21'h03046;
  localparam code_t HIRA_E = 21'h03048;

endpackage

// ----- rtl/core/ksc_convert.sv -----
// Combinational kana conversion of one word and vowel class of the result.
module ksc_convert (
  input  ksc_pkg::ksc_in_t  in_word,
  input  ksc_pkg::mode_t    mode,
  input  ksc_pkg::vowel_t   prev_vowel,
  output ksc_pkg::ksc_out_t out_word,
  output ksc_pkg::vowel_t   vowel_nxt
);

  localparam int TAB_DEPTH = 86;

  localparam ksc_pkg::vowel_t VOWEL_TAB [TAB_DEPTH] = '{
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd3, 3'd3, 3'd5, 3'd5,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0
  };

  localparam int IDX_W = $clog2(TAB_DEPTH);

  function automatic ksc_pkg::vowel_t vowel_of(input ksc_pkg::code_t c);
    ksc_pkg::code_t  hoff;
    ksc_pkg::code_t  koff;
    ksc_pkg::vowel_t v;
    hoff = c - ksc_pkg::HIRA_FIRST;
    koff = c - ksc_pkg::KATA_FIRST;
    v    = ksc_pkg::VOWEL_NONE;
    if (c >= ksc_pkg::HIRA_FIRST && c <= ksc_pkg::HIRA_LAST) begin
      v = VOWEL_TAB[hoff[IDX_W-1:0]];
    end else if (c >= ksc_pkg::KATA_FIRST && c < ksc_pkg::KATA_LAST) begin
      v = VOWEL_TAB[koff[IDX_W-1:0]];
    end else begin
      case (c)
        21'h030F4: v = ksc_pkg::VOWEL_U;
        21'h030F5: v = ksc_pkg::VOWEL_A;
        21'h030F6: v = ksc_pkg::VOWEL_E;
        21'h030F7: v = ksc_pkg::VOWEL_A;
        21'h030F8: v = ksc_pkg::VOWEL_I;
        21'h030F9: v = ksc_pkg::VOWEL_E;
        21'h030FA: v = ksc_pkg::VOWEL_O;
        default:   v = ksc_pkg::VOWEL_NONE;
      endcase
    end
    return v;
  endfunction

  ksc_pkg::code_t  c;
  ksc_pkg::code_t  r;
  ksc_pkg::vowel_t pv;

  always_comb begin
    c  = in_word.code_point;
    r  = c;
    // start of text drops the carried vowel before this word is converted
    pv = in_word.start_of_text ? ksc_pkg::VOWEL_NONE : prev_vowel;
    case (mode)
      ksc_pkg::MODE_K2H: begin
        if (c == ksc_pkg::PROLONG_MARK) begin
          case (pv)
            ksc_pkg::VOWEL_A: r = ksc_pkg::HIRA_A;
            ksc_pkg::VOWEL_I: r = ksc_pkg::HIRA_I;
            ksc_pkg::VOWEL_U: r = ksc_pkg::HIRA_U;
            ksc_pkg::VOWEL_E: r = ksc_pkg::HIRA_E;
            ksc_pkg::VOWEL_O: r = ksc_pkg::HIRA_U;
            default:          r = c;
          endcase
        end else if (c >= ksc_pkg::KATA_FIRST && c <= ksc_pkg::KATA_LAST) begin
          r = c - ksc_pkg::KANA_SHIFT;
        end
      end
      ksc_pkg::MODE_H2K: begin
        if (c >= ksc_pkg::HIRA_FIRST && c <= ksc_pkg::HIRA_LAST) begin
          r = c + ksc_pkg::KANA_SHIFT;
        end
      end
      default: r = c;
    endcase
    out_word.converted_point = r;
    out_word.was_changed     = (r != c);
    vowel_nxt                = vowel_of(r);
  end

endmodule

// ----- rtl/core/kana_script_converter.sv -----
// Top level: input register, conversion logic, result register and vowel state.
// Accepts one code point per cycle unless the output stalls, and returns one
// converted word per word taken, in order; each word passes the input register,
// then the result register. The vowel class of each result is written to a 3-bit
// register in the same cycle that result enters the output register, so the next
// word sees it at once. cfg_ready is always high; write the mode only while idle.
module kana_script_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  ksc_pkg::mode_t     cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  ksc_pkg::ksc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ksc_pkg::ksc_out_t  out_data
);

  ksc_pkg::mode_t    mode_r;
  logic              in_vld_r, in_vld_nxt;
  ksc_pkg::ksc_in_t  in_word_r;
  logic              out_vld_r, out_vld_nxt;
  ksc_pkg::ksc_out_t out_word_r;
  ksc_pkg::vowel_t   prev_vowel_r, prev_vowel_nxt;
  ksc_pkg::ksc_out_t conv_word;
  ksc_pkg::vowel_t   conv_vowel;
  logic              advance;

  ksc_convert u_convert (
    .in_word    (in_word_r),
    .mode       (mode_r),
    .prev_vowel (prev_vowel_r),
    .out_word   (conv_word),
    .vowel_nxt  (conv_vowel)
  );

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  always_comb begin
    in_vld_nxt     = in_ready ? in_valid : in_vld_r;
    out_vld_nxt    = out_vld_r;
    prev_vowel_nxt = prev_vowel_r;
    if (advance) begin
      out_vld_nxt    = 1'b1;
      prev_vowel_nxt = conv_vowel;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ksc_pkg::MODE_PASS;
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      prev_vowel_r <= ksc_pkg::VOWEL_NONE;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      in_vld_r     <= in_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      prev_vowel_r <= prev_vowel_nxt;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (advance) begin
      out_word_r <= conv_word;
    end
  end

endmodule

// ----- rtl/core/ksc_checker.sv -----
// Port-level checks for the kana script converter, bound to the top level.
module ksc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ksc_pkg::ksc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_accept_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted word did not reach the output");

  a_changed_is_kana: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_changed |->
      (out_data.converted_point >= ksc_pkg::HIRA_FIRST &&
       out_data.converted_point <= ksc_pkg::HIRA_LAST) ||
      (out_data.converted_point >= ksc_pkg::KATA_FIRST &&
       out_data.converted_point <= ksc_pkg::KATA_SMALL_KE))
    else $error("changed word outside kana ranges");

endmodule

bind kana_script_converter ksc_checker u_ksc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- bench/kana_script_converter_checker.sv -----
// Watches the kana converter's channels, predicts each converted word and compares it.
module kana_script_converter_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  ksc_pkg::mode_t     cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ksc_pkg::ksc_in_t   in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ksc_pkg::ksc_out_t  out_data,
  output int                 fail_count,
  output int                 pending
);

  // Katakana letters past small ke that still carry a vowel.
  localparam ksc_pkg::code_t KATA_VA = 21'h030F7;
  localparam ksc_pkg::code_t KATA_VI = 21'h030F8;
  localparam ksc_pkg::code_t KATA_VE = 21'h030F9;
  localparam ksc_pkg::code_t KATA_VO = 21'h030FA;

  ksc_pkg::mode_t    mode_q;
  ksc_pkg::vowel_t   vowel_q;
  ksc_pkg::ksc_out_t expected_words[$];

  function automatic ksc_pkg::vowel_t vowel_in_order(int unsigned k);
    case (k)
      0:       return ksc_pkg::VOWEL_A;
      1:       return ksc_pkg::VOWEL_I;
      2:       return ksc_pkg::VOWEL_U;
      3:       return ksc_pkg::VOWEL_E;
      default: return ksc_pkg::VOWEL_O;
    endcase
  endfunction

  // Vowel of a kana by its offset from small a, walking the syllabary rows.
  function automatic ksc_pkg::vowel_t row_vowel(int unsigned o);
    if (o < 30) return vowel_in_order((o % 10) / 2);
    if (o < 41) begin
      case (o - 30)
        0, 1:    return ksc_pkg::VOWEL_A;
        2, 3:    return ksc_pkg::VOWEL_I;
        4, 5, 6: return ksc_pkg::VOWEL_U;
        7, 8:    return ksc_pkg::VOWEL_E;
        default: return ksc_pkg::VOWEL_O;
      endcase
    end
    if (o < 46) return vowel_in_order(o - 41);
    if (o < 61) return vowel_in_order((o - 46) / 3);
    if (o < 66) return vowel_in_order(o - 61);
    if (o < 72) begin
      case ((o - 66) / 2)
        0:       return ksc_pkg::VOWEL_A;
        1:       return ksc_pkg::VOWEL_U;
        default: return ksc_pkg::VOWEL_O;
      endcase
    end
    if (o < 77) return vowel_in_order(o - 72);
    if (o < 82) begin
      case (o - 77)
        0, 1:    return ksc_pkg::VOWEL_A;
        2:       return ksc_pkg::VOWEL_I;
        3:       return ksc_pkg::VOWEL_E;
        default: return ksc_pkg::VOWEL_O;
      endcase
    end
    return ksc_pkg::VOWEL_NONE;
  endfunction

  function automatic ksc_pkg::vowel_t vowel_class(ksc_pkg::code_t c);
    if (c >= ksc_pkg::HIRA_FIRST && c <= ksc_pkg::HIRA_LAST)
      return row_vowel(c - ksc_pkg::HIRA_FIRST);
    if (c >= ksc_pkg::KATA_FIRST && c < ksc_pkg::KATA_LAST)
      return row_vowel(c - ksc_pkg::KATA_FIRST);
    case (c)
      ksc_pkg::KATA_LAST:     return ksc_pkg::VOWEL_U;
      ksc_pkg::KATA_SMALL_KA: return ksc_pkg::VOWEL_A;
      ksc_pkg::KATA_SMALL_KE: return ksc_pkg::VOWEL_E;
      KATA_VA:                return ksc_pkg::VOWEL_A;
      KATA_VI:                return ksc_pkg::VOWEL_I;
      KATA_VE:                return ksc_pkg::VOWEL_E;
      KATA_VO:                return ksc_pkg::VOWEL_O;
      default:                return ksc_pkg::VOWEL_NONE;
    endcase
  endfunction

  function automatic ksc_pkg::ksc_out_t convert(ksc_pkg::ksc_in_t w, ksc_pkg::mode_t m,
                                                ksc_pkg::vowel_t prev);
    ksc_pkg::code_t    c;
    ksc_pkg::code_t    r;
    ksc_pkg::ksc_out_t res;
    c = w.code_point;
    r = c;
    case (m)
      ksc_pkg::MODE_K2H: begin
        if (c == ksc_pkg::KATA_SMALL_KA || c == ksc_pkg::KATA_SMALL_KE) begin
          r = c;
        end else if (c == ksc_pkg::PROLONG_MARK) begin
          case (prev)
            ksc_pkg::VOWEL_A:                   r = ksc_pkg::HIRA_A;
            ksc_pkg::VOWEL_I:                   r = ksc_pkg::HIRA_I;
            ksc_pkg::VOWEL_U, ksc_pkg::VOWEL_O: r = ksc_pkg::HIRA_U;
            ksc_pkg::VOWEL_E:                   r = ksc_pkg::HIRA_E;
            default:                            r = c;
          endcase
        end else if (c >= ksc_pkg::KATA_FIRST && c <= ksc_pkg::KATA_LAST) begin
          r = c - ksc_pkg::KANA_SHIFT;
        end
      end
      ksc_pkg::MODE_H2K: begin
        if (c >= ksc_pkg::HIRA_FIRST && c <= ksc_pkg::HIRA_LAST) r = c + ksc_pkg::KANA_SHIFT;
      end
      default: r = c;
    endcase
    res.converted_point = r;
    res.was_changed     = (r != c);
    return res;
  endfunction

  always @(posedge clk) begin
    ksc_pkg::ksc_out_t want;
    ksc_pkg::vowel_t   prev;
    if (!rst_n) begin
      mode_q     = ksc_pkg::MODE_PASS;
      vowel_q    = ksc_pkg::VOWEL_NONE;
      fail_count = 0;
      expected_words.delete();
    end else begin
      // Check the outgoing word before queueing the incoming one.
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: got %h/%b", out_data.converted_point,
                     out_data.was_changed);
        end else begin
          want = expected_words.pop_front();
          if (out_data.converted_point !== want.converted_point ||
              out_data.was_changed !== want.was_changed) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h/%b got %h/%b", want.converted_point,
                       want.was_changed, out_data.converted_point, out_data.was_changed);
          end
        end
      end
      if (in_valid && in_ready) begin
        prev = in_data.start_of_text ? ksc_pkg::VOWEL_NONE : vowel_q;
        want = convert(in_data, mode_q, prev);
        vowel_q = vowel_class(want.converted_point);
        expected_words.push_back(want);
      end
      if (cfg_valid && cfg_ready) mode_q = cfg_data;
    end
    pending = expected_words.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end

endmodule

// ----- bench/kana_script_converter_test.sv -----
// Stimulus, stall control and verdict for the kana script converter.
module kana_script_converter_test;

  localparam ksc_pkg::mode_t MODE_SPARE     = 2'd3;
  localparam int             PHASE_WORDS    = 170;
  localparam int             PHASES         = 8;
  localparam int             WATCHDOG_LIMIT = 2000;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  ksc_pkg::mode_t    cfg_data;
  logic              in_valid;
  logic              in_ready;
  ksc_pkg::ksc_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  ksc_pkg::ksc_out_t out_data;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  kana_script_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  kana_script_converter_checker conv_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input ksc_pkg::code_t c, input logic sot);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{code_point: c, start_of_text: sot};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_mode(input ksc_pkg::mode_t m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic ksc_pkg::mode_t phase_mode(int p);
    case (p)
      0, 3, 6: return ksc_pkg::MODE_K2H;
      1, 4, 7: return ksc_pkg::MODE_H2K;
      2:       return ksc_pkg::MODE_PASS;
      default: return MODE_SPARE;
    endcase
  endfunction

  // Mostly kana text with prolonged marks; the rest is boundary and wide noise.
  function automatic ksc_pkg::ksc_in_t random_word();
    ksc_pkg::ksc_in_t w;
    int unsigned      kind;
    kind = $urandom_range(99);
    w.start_of_text = ($urandom_range(19) == 0);
    if (kind < 30)
      w.code_point = ksc_pkg::KATA_FIRST + ksc_pkg::code_t'($urandom_range(8'h59));
    else if (kind < 55)
      w.code_point = ksc_pkg::HIRA_FIRST + ksc_pkg::code_t'($urandom_range(8'h55));
    else if (kind < 75)
      w.code_point = ksc_pkg::PROLONG_MARK;
    else if (kind < 80)
      w.code_point = 21'h030F0 + ksc_pkg::code_t'($urandom_range(15));
    else if (kind < 85)
      w.code_point = ksc_pkg::code_t'($urandom_range(21'h03030, 21'h03110));
    else if (kind < 95)
      w.code_point = ksc_pkg::code_t'($urandom);
    else
      w.code_point = ksc_pkg::code_t'($urandom_range(21'h110000, 21'h1FFFFF));
    return w;
  endfunction

  initial begin
    ksc_pkg::ksc_in_t w;
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = ksc_pkg::MODE_PASS;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Katakana to hiragana: shift range ends, small ka/ke, prolonged mark cases.
    write_mode(ksc_pkg::MODE_K2H);
    send_word(ksc_pkg::PROLONG_MARK, 1'b1);
    send_word(21'h030AB, 1'b0);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    send_word(ksc_pkg::KATA_FIRST, 1'b0);
    send_word(ksc_pkg::KATA_LAST, 1'b0);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    send_word(ksc_pkg::KATA_SMALL_KA, 1'b0);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    send_word(21'h030ED, 1'b0);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    send_word(ksc_pkg::KATA_SMALL_KE, 1'b1);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    send_word(21'h1FFFFF, 1'b0);
    // Hiragana to katakana: range ends and their outer neighbors.
    write_mode(ksc_pkg::MODE_H2K);
    send_word(ksc_pkg::HIRA_FIRST, 1'b1);
    send_word(ksc_pkg::HIRA_LAST, 1'b0);
    send_word(ksc_pkg::HIRA_FIRST - 21'd1, 1'b0);
    send_word(ksc_pkg::HIRA_LAST + 21'd1, 1'b0);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    write_mode(ksc_pkg::MODE_PASS);
    send_word(21'h030AB, 1'b0);
    send_word(ksc_pkg::PROLONG_MARK, 1'b0);
    send_word(21'h000000, 1'b1);
    write_mode(MODE_SPARE);
    send_word(21'h030AB, 1'b0);
    send_word(ksc_pkg::HIRA_A, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_mode(phase_mode(p));
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 55; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      repeat (PHASE_WORDS) begin
        w = random_word();
        send_word(w.code_point, w.start_of_text);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- kana_script_converter.f -----
rtl/core/ksc_pkg.sv
rtl/core/ksc_convert.sv
rtl/core/kana_script_converter.sv
rtl/core/ksc_checker.sv
bench/kana_script_converter_checker.sv
bench/kana_script_converter_test.sv
